[rtl/core/pcc_pkg.sv]
`timescale 1ns / 1ps
// Package for the polygon corner cutting block: fixed-point constants,
// configuration register indexes, job case codes and the job sequence table.
// No dependencies.
package pcc_pkg;

    localparam int FACTOR_BITS   = 17;
    localparam int FRAC_BITS     = 16;
    localparam int CFG_IDX_BITS  = 4;
    localparam logic [FACTOR_BITS-1:0] FACTOR_ONE   = 17'h10000;
    localparam logic [FACTOR_BITS-1:0] FACTOR_RESET = 17'h08000;

    localparam logic [CFG_IDX_BITS-1:0] REG_CUT_FACTOR = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BYPASS     = 4'd1;

    // Job sequence kinds, chosen when a vertex is taken.
    localparam logic [2:0] CASE_BYPASS     = 3'd0;
    localparam logic [2:0] CASE_BYPASS_END = 3'd1;
    localparam logic [2:0] CASE_SINGLE     = 3'd2;
    localparam logic [2:0] CASE_TWO_END    = 3'd3;
    localparam logic [2:0] CASE_MID        = 3'd4;
    localparam logic [2:0] CASE_LAST       = 3'd5;

    // Vertex selects into the captured vertex set.
    localparam logic [2:0] SEL_V      = 3'd0;
    localparam logic [2:0] SEL_OLDER  = 3'd1;
    localparam logic [2:0] SEL_RECENT = 3'd2;
    localparam logic [2:0] SEL_FIRST  = 3'd3;
    localparam logic [2:0] SEL_SECOND = 3'd4;

    typedef struct packed {
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic       fin;
        logic       last;
    } t_job_sel;

    // Each job produces the point a + (b - a) * f.
    function automatic t_job_sel job_sel(input logic [2:0] kind, input logic [2:0] idx);
        t_job_sel s;
        s = '{a_sel: SEL_V, b_sel: SEL_V, fin: 1'b0, last: 1'b1};
        case (kind)
            CASE_BYPASS: begin
                s = '{a_sel: SEL_V, b_sel: SEL_V, fin: 1'b0, last: 1'b1};
            end
            CASE_BYPASS_END: begin
                s = '{a_sel: SEL_V, b_sel: SEL_V, fin: 1'b1, last: 1'b1};
            end
            CASE_SINGLE: begin
                s = '{a_sel: SEL_V, b_sel: SEL_V, fin: idx[0], last: idx[0]};
            end
            CASE_TWO_END: begin
                case (idx)
                    3'd0, 3'd1: s = '{a_sel: SEL_V, b_sel: SEL_FIRST, fin: 1'b0, last: 1'b0};
                    3'd2: s = '{a_sel: SEL_FIRST, b_sel: SEL_V, fin: 1'b0, last: 1'b0};
                    default: s = '{a_sel: SEL_FIRST, b_sel: SEL_V, fin: 1'b1, last: 1'b1};
                endcase
            end
            CASE_MID: begin
                case (idx)
                    3'd0: s = '{a_sel: SEL_RECENT, b_sel: SEL_OLDER, fin: 1'b0, last: 1'b0};
                    default: s = '{a_sel: SEL_RECENT, b_sel: SEL_V, fin: 1'b0, last: 1'b1};
                endcase
            end
            CASE_LAST: begin
                case (idx)
                    3'd0: s = '{a_sel: SEL_RECENT, b_sel: SEL_OLDER, fin: 1'b0, last: 1'b0};
                    3'd1: s = '{a_sel: SEL_RECENT, b_sel: SEL_V, fin: 1'b0, last: 1'b0};
                    3'd2: s = '{a_sel: SEL_V, b_sel: SEL_RECENT, fin: 1'b0, last: 1'b0};
                    3'd3: s = '{a_sel: SEL_V, b_sel: SEL_FIRST, fin: 1'b0, last: 1'b0};
                    3'd4: s = '{a_sel: SEL_FIRST, b_sel: SEL_V, fin: 1'b0, last: 1'b0};
                    default: s = '{a_sel: SEL_FIRST, b_sel: SEL_SECOND, fin: 1'b1, last: 1'b1};
                endcase
            end
            default: begin
                s = '{a_sel: SEL_V, b_sel: SEL_V, fin: 1'b0, last: 1'b1};
            end
        endcase
        return s;
    endfunction

endpackage

[rtl/core/pcc_sequencer.sv]
`timescale 1ns / 1ps
// Vertex sequencer: polygon history, the captured vertex set of the current
// beat and one cut job per cycle while i_job_ready. Depends on pcc_pkg.
module pcc_sequencer #(
    parameter int COORD_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_bypass,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    input  logic                  i_end,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output logic [COORD_BITS-1:0] o_ax,
    output logic [COORD_BITS-1:0] o_ay,
    output logic [COORD_BITS-1:0] o_bx,
    output logic [COORD_BITS-1:0] o_by,
    output logic                  o_fin
);
    import pcc_pkg::*;

    logic [1:0]            r_seen;
    logic [1:0]            n_seen;
    logic                  r_busy;
    logic                  n_busy;
    logic [2:0]            r_idx;
    logic [2:0]            n_idx;
    logic [2:0]            r_kind;
    logic [2:0]            n_kind;
    logic                  has_job;

    logic [COORD_BITS-1:0] r_first_x, r_first_y, r_second_x, r_second_y;
    logic [COORD_BITS-1:0] r_older_x, r_older_y, r_recent_x, r_recent_y;
    logic [COORD_BITS-1:0] r_sv_x, r_sv_y, r_so_x, r_so_y, r_sr_x, r_sr_y;
    logic [COORD_BITS-1:0] r_sf_x, r_sf_y, r_ss_x, r_ss_y;

    logic                  in_acc;
    logic                  job_take;
    t_job_sel              sel;

    assign sel         = job_sel(r_kind, r_idx);
    assign job_take    = r_busy && i_job_ready;
    assign o_in_stall  = r_busy && !(job_take && sel.last);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_job_valid = r_busy;
    assign o_fin       = sel.fin;

    always_comb begin
        case (sel.a_sel)
            SEL_OLDER:  begin o_ax = r_so_x; o_ay = r_so_y; end
            SEL_RECENT: begin o_ax = r_sr_x; o_ay = r_sr_y; end
            SEL_FIRST:  begin o_ax = r_sf_x; o_ay = r_sf_y; end
            SEL_SECOND: begin o_ax = r_ss_x; o_ay = r_ss_y; end
            default:    begin o_ax = r_sv_x; o_ay = r_sv_y; end
        endcase
        case (sel.b_sel)
            SEL_OLDER:  begin o_bx = r_so_x; o_by = r_so_y; end
            SEL_RECENT: begin o_bx = r_sr_x; o_by = r_sr_y; end
            SEL_FIRST:  begin o_bx = r_sf_x; o_by = r_sf_y; end
            SEL_SECOND: begin o_bx = r_ss_x; o_by = r_ss_y; end
            default:    begin o_bx = r_sv_x; o_by = r_sv_y; end
        endcase
    end

    always_comb begin
        n_seen  = r_seen;
        has_job = 1'b1;
        n_kind  = r_kind;
        if (i_bypass) begin
            n_kind = i_end ? CASE_BYPASS_END : CASE_BYPASS;
        end else begin
            case (r_seen)
                2'd0: begin
                    n_kind  = CASE_SINGLE;
                    has_job = i_end;
                    n_seen  = i_end ? 2'd0 : 2'd1;
                end
                2'd1: begin
                    n_kind  = CASE_TWO_END;
                    has_job = i_end;
                    n_seen  = i_end ? 2'd0 : 2'd2;
                end
                default: begin
                    n_kind = i_end ? CASE_LAST : CASE_MID;
                    n_seen = i_end ? 2'd0 : 2'd2;
                end
            endcase
        end

        n_busy = r_busy;
        n_idx  = r_idx;
        if (in_acc) begin
            n_busy = has_job;
            n_idx  = 3'd0;
        end else if (job_take) begin
            n_busy = !sel.last;
            n_idx  = r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 2'd0;
            r_busy <= 1'b0;
            r_idx  <= 3'd0;
            r_kind <= CASE_BYPASS;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            if (in_acc) begin
                r_seen <= n_seen;
                r_kind <= n_kind;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sv_x <= i_px;       r_sv_y <= i_py;
            r_so_x <= r_older_x;  r_so_y <= r_older_y;
            r_sr_x <= r_recent_x; r_sr_y <= r_recent_y;
            r_sf_x <= r_first_x;  r_sf_y <= r_first_y;
            r_ss_x <= r_second_x; r_ss_y <= r_second_y;
            if (!i_bypass && !i_end) begin
                case (r_seen)
                    2'd0: begin
                        r_first_x  <= i_px;       r_first_y  <= i_py;
                        r_recent_x <= i_px;       r_recent_y <= i_py;
                    end
                    2'd1: begin
                        r_second_x <= i_px;       r_second_y <= i_py;
                        r_older_x  <= r_recent_x; r_older_y  <= r_recent_y;
                        r_recent_x <= i_px;       r_recent_y <= i_py;
                    end
                    default: begin
                        r_older_x  <= r_recent_x; r_older_y  <= r_recent_y;
                        r_recent_x <= i_px;       r_recent_y <= i_py;
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_seen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen != 2'd3)
        else $error("vertex count left its range");
    a_no_job_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !has_job |=> !r_busy)
        else $error("sequencer busy after a beat without points");
    a_fin_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_take && sel.fin |-> sel.last)
        else $error("final point issued before the last job");
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_job_ready |=> r_busy && $stable(r_idx))
        else $error("job sequence moved while held");
`endif

endmodule

[rtl/core/pcc_cut_pipe.sv]
`timescale 1ns / 1ps
// Cut arithmetic pipeline: difference, product by the factor, shift and add,
// then the result register. Depends on pcc_pkg.
module pcc_cut_pipe #(
    parameter int COORD_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [pcc_pkg::FACTOR_BITS-1:0] i_factor,
    input  logic                          i_job_valid,
    output logic                          o_job_ready,
    input  logic [COORD_BITS-1:0]         i_ax,
    input  logic [COORD_BITS-1:0]         i_ay,
    input  logic [COORD_BITS-1:0]         i_bx,
    input  logic [COORD_BITS-1:0]         i_by,
    input  logic                          i_fin,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [COORD_BITS-1:0]         o_qx,
    output logic [COORD_BITS-1:0]         o_qy,
    output logic                          o_final_point
);
    import pcc_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + FACTOR_BITS + 2;
    localparam int SW = PW - FRAC_BITS;

    logic                         r_s1_valid, r_s2_valid, r_out_valid;
    logic                         r_s1_fin, r_s2_fin, r_out_fin;
    logic [COORD_BITS-1:0]        r_s1_ax, r_s1_ay, r_s2_ax, r_s2_ay;
    logic signed [DW-1:0]         r_dx, r_dy;
    logic signed [DW-1:0]         n_dx, n_dy;
    logic signed [PW-1:0]         r_px, r_py;
    logic signed [PW-1:0]         n_px, n_py;
    logic signed [FACTOR_BITS:0]  f_s;
    logic signed [SW-1:0]         n_sx, n_sy;
    logic [COORD_BITS-1:0]        r_qx, r_qy;
    logic                         en1, en2, en_out;

    assign en_out      = !r_out_valid || !i_out_stall;
    assign en2         = !r_s2_valid || en_out;
    assign en1         = !r_s1_valid || en2;
    assign o_job_ready = en1;

    assign n_dx = $signed({i_bx[COORD_BITS-1], i_bx}) - $signed({i_ax[COORD_BITS-1], i_ax});
    assign n_dy = $signed({i_by[COORD_BITS-1], i_by}) - $signed({i_ay[COORD_BITS-1], i_ay});
    assign f_s  = $signed({1'b0, i_factor});
    assign n_px = PW'(r_dx * f_s);
    assign n_py = PW'(r_dy * f_s);
    assign n_sx = $signed({{(SW-COORD_BITS){r_s2_ax[COORD_BITS-1]}}, r_s2_ax})
                + $signed(r_px[PW-1:FRAC_BITS]);
    assign n_sy = $signed({{(SW-COORD_BITS){r_s2_ay[COORD_BITS-1]}}, r_s2_ay})
                + $signed(r_py[PW-1:FRAC_BITS]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_valid <= i_job_valid;
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en_out) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_ax  <= i_ax;
            r_s1_ay  <= i_ay;
            r_dx     <= n_dx;
            r_dy     <= n_dy;
            r_s1_fin <= i_fin;
        end
        if (en2) begin
            r_s2_ax  <= r_s1_ax;
            r_s2_ay  <= r_s1_ay;
            r_px     <= n_px;
            r_py     <= n_py;
            r_s2_fin <= r_s1_fin;
        end
        if (en_out) begin
            r_qx      <= n_sx[COORD_BITS-1:0];
            r_qy      <= n_sy[COORD_BITS-1:0];
            r_out_fin <= r_s2_fin;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_qx          = r_qx;
    assign o_qy          = r_qy;
    assign o_final_point = r_out_fin;

`ifndef SYNTHESIS
    a_s2_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !en_out |=> r_s2_valid && $stable(r_px) && $stable(r_py))
        else $error("product stage lost while the result was held");
    a_s1_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !en2 |=> r_s1_valid && $stable(r_dx) && $stable(r_dy))
        else $error("difference stage lost while held");
    a_zero_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en2 && r_s1_valid && r_dx == '0 |=> r_px == '0)
        else $error("product of a zero difference is not zero");
`endif

endmodule

[rtl/core/polygon_corner_cutting.sv]
`timescale 1ns / 1ps
// Top level of the polygon corner cutting block: configuration registers,
// vertex sequencer and cut arithmetic pipeline. Depends on pcc_pkg,
// pcc_sequencer and pcc_cut_pipe.
//
//  Channel  Direction  Handshake                 Beat
//  in       input      i_in_valid / o_in_stall   one vertex (px, py, end_of_polygon)
//  out      output     o_out_valid / i_out_stall one point (qx, qy, final_point)
//  cfg      input      i_cfg_valid / o_cfg_ready register index and write data
//
// A vertex gives zero to six points; the points leave at one per cycle while
// the output is not stalled. A vertex that gives no point leaves the
// sequencer idle; otherwise the next vertex is taken with the last job of
// the one before. The first point of a vertex passes through the captured
// vertex set, then the difference, product and result registers. Reset
// clears the vertex count, job sequence and valid flags.
// A stall holds the result register; bubbles in the pipeline keep filling.
module polygon_corner_cutting #(
    parameter int COORD_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [COORD_BITS-1:0]             i_px,
    input  logic [COORD_BITS-1:0]             i_py,
    input  logic                              i_end_of_polygon,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [COORD_BITS-1:0]             o_qx,
    output logic [COORD_BITS-1:0]             o_qy,
    output logic                              o_final_point,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [pcc_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [pcc_pkg::FACTOR_BITS-1:0]   i_cfg_data
);
    import pcc_pkg::*;

    logic [FACTOR_BITS-1:0] r_factor;
    logic                   r_bypass;
    logic                   job_valid, job_ready, job_fin;
    logic [COORD_BITS-1:0]  job_ax, job_ay, job_bx, job_by;

    assign o_cfg_ready = 1'b1;

    // The factor is clamped to one on write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= FACTOR_RESET;
            r_bypass <= 1'b0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_CUT_FACTOR) begin
                r_factor <= (i_cfg_data > FACTOR_ONE) ? FACTOR_ONE : i_cfg_data;
            end else if (i_cfg_index == REG_BYPASS) begin
                r_bypass <= i_cfg_data[0];
            end
        end
    end

    pcc_sequencer #(
        .COORD_BITS (COORD_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bypass    (r_bypass),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_px        (i_px),
        .i_py        (i_py),
        .i_end       (i_end_of_polygon),
        .o_job_valid (job_valid),
        .i_job_ready (job_ready),
        .o_ax        (job_ax),
        .o_ay        (job_ay),
        .o_bx        (job_bx),
        .o_by        (job_by),
        .o_fin       (job_fin)
    );

    pcc_cut_pipe #(
        .COORD_BITS (COORD_BITS)
    ) u_pipe (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_factor      (r_factor),
        .i_job_valid   (job_valid),
        .o_job_ready   (job_ready),
        .i_ax          (job_ax),
        .i_ay          (job_ay),
        .i_bx          (job_bx),
        .i_by          (job_by),
        .i_fin         (job_fin),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_qx          (o_qx),
        .o_qy          (o_qy),
        .o_final_point (o_final_point)
    );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for polygon_corner_cutting: streams closed polygons,
// predicts every smoothed point and compares each output beat in order.
// Depends on pcc_pkg and the polygon_corner_cutting RTL.
module testbench;
    import pcc_pkg::*;

    localparam int CB = 24;

    typedef struct packed {
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
    } t_vertex;

    typedef struct packed {
        logic [CB-1:0] qx;
        logic [CB-1:0] qy;
        logic          final_point;
    } t_point;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic [CB-1:0]           px = '0;
    logic [CB-1:0]           py = '0;
    logic                    end_mark = 1'b0;
    logic                    out_stall = 1'b0;
    logic                    cfg_valid = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [FACTOR_BITS-1:0]  cfg_data = '0;
    logic                    in_stall;
    logic                    out_valid;
    logic [CB-1:0]           qx;
    logic [CB-1:0]           qy;
    logic                    final_point;
    logic                    cfg_ready;

    bit                      calm = 1'b0;
    int                      error_count = 0;

    logic [FACTOR_BITS-1:0]  cut_factor_reg = FACTOR_RESET;
    bit                      bypass_on = 1'b0;
    t_vertex                 poly_first = '0;
    t_vertex                 poly_second = '0;
    t_vertex                 poly_older = '0;
    t_vertex                 poly_recent = '0;
    int                      vertices_seen = 0;
    t_point                  pending_points[$];

    polygon_corner_cutting #(
        .COORD_BITS(CB)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_px            (px),
        .i_py            (py),
        .i_end_of_polygon(end_mark),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_qx            (qx),
        .o_qy            (qy),
        .o_final_point   (final_point),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 26);
    end

    // Moves point a towards b by the clamped factor, rounding down.
    function automatic logic [CB-1:0] cut_toward(input t_vertex a, input t_vertex b,
                                                 input bit use_y);
        longint from;
        longint span;
        longint f;
        logic [CB-1:0] point;
        from = use_y ? longint'(a.y) : longint'(a.x);
        span = (use_y ? longint'(b.y) : longint'(b.x)) - from;
        f = (cut_factor_reg > FACTOR_ONE) ? longint'(FACTOR_ONE) : longint'(cut_factor_reg);
        point = CB'(from + ((span * f) >>> FRAC_BITS));
        return point;
    endfunction

    task automatic enqueue_point(input t_point p);
        pending_points = {pending_points, p};
    endtask

    task automatic queue_pair(input t_vertex prev, input t_vertex a, input t_vertex next,
                              input logic fin);
        enqueue_point('{cut_toward(a, prev, 0), cut_toward(a, prev, 1), 1'b0});
        enqueue_point('{cut_toward(a, next, 0), cut_toward(a, next, 1), fin});
    endtask

    task automatic predict_points(input t_vertex v, input logic last_mark);
        if (bypass_on) begin
            enqueue_point('{v.x, v.y, last_mark});
        end else if (vertices_seen == 0) begin
            if (last_mark) begin
                queue_pair(v, v, v, 1'b1);
            end else begin
                poly_first = v;
                poly_recent = v;
                vertices_seen = 1;
            end
        end else if (vertices_seen == 1) begin
            if (last_mark) begin
                queue_pair(poly_first, v, poly_first, 1'b0);
                queue_pair(v, poly_first, v, 1'b1);
                vertices_seen = 0;
            end else begin
                poly_second = v;
                poly_older = poly_recent;
                poly_recent = v;
                vertices_seen = 2;
            end
        end else begin
            queue_pair(poly_older, poly_recent, v, 1'b0);
            if (last_mark) begin
                queue_pair(poly_recent, v, poly_first, 1'b0);
                queue_pair(v, poly_first, poly_second, 1'b1);
                vertices_seen = 0;
            end else begin
                poly_older = poly_recent;
                poly_recent = v;
            end
        end
    endtask

    always @(posedge clk) begin
        t_point want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_points.size() == 0) begin
                $error("unexpected point: qx %h qy %h final_point %b", qx, qy, final_point);
                error_count++;
            end else begin
                want = pending_points.pop_front();
                if (qx !== want.qx) begin
                    $error("qx: expected %h, actual %h", want.qx, qx);
                    error_count++;
                end
                if (qy !== want.qy) begin
                    $error("qy: expected %h, actual %h", want.qy, qy);
                    error_count++;
                end
                if (final_point !== want.final_point) begin
                    $error("final_point: expected %b, actual %b", want.final_point, final_point);
                    error_count++;
                end
            end
        end
    end

    task automatic send_vertex(input t_vertex v, input logic last_mark);
        while (!calm && $urandom_range(99) < 26) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        px <= v.x;
        py <= v.y;
        end_mark <= last_mark;
        do @(posedge clk); while (in_stall);
        predict_points(v, last_mark);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_BITS-1:0] index,
                                  input logic [FACTOR_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_CUT_FACTOR) begin
            cut_factor_reg = value;
        end else if (index == REG_BYPASS) begin
            bypass_on = value[0];
        end
        @(posedge clk);
    endtask

    function automatic t_vertex make_vertex(input logic [CB-1:0] x, input logic [CB-1:0] y);
        t_vertex v;
        v.x = x;
        v.y = y;
        return v;
    endfunction

    function automatic logic [CB-1:0] random_coord();
        logic [CB-1:0] c;
        case ($urandom_range(7))
            0: c = {1'b0, {(CB-1){1'b1}}};
            1: c = {1'b1, {(CB-1){1'b0}}};
            2, 3, 4: c = CB'($urandom);
            default: c = CB'($urandom_range(0, 4095) - 2048);
        endcase
        return c;
    endfunction

    function automatic logic [FACTOR_BITS-1:0] random_factor();
        logic [FACTOR_BITS-1:0] f;
        case ($urandom_range(5))
            0: f = '0;
            1: f = FACTOR_ONE;
            2: f = FACTOR_BITS'($urandom_range(FACTOR_ONE + 1, 2**FACTOR_BITS - 1));
            default: f = FACTOR_BITS'($urandom_range(0, FACTOR_ONE));
        endcase
        return f;
    endfunction

    task automatic test_polygon_shapes();
        t_vertex top;
        t_vertex bottom;
        top = make_vertex({1'b0, {(CB-1){1'b1}}}, {1'b0, {(CB-1){1'b1}}});
        bottom = make_vertex({1'b1, {(CB-1){1'b0}}}, {1'b1, {(CB-1){1'b0}}});
        send_vertex(top, 1'b1);
        send_vertex(bottom, 1'b1);
        send_vertex(top, 1'b0);
        send_vertex(bottom, 1'b1);
        send_vertex(bottom, 1'b0);
        send_vertex(make_vertex(top.x, bottom.y), 1'b0);
        send_vertex(make_vertex('0, top.y), 1'b1);
        wait_idle();
    endtask

    task automatic test_factor_extremes();
        logic [FACTOR_BITS-1:0] factors[3];
        factors = '{'0, FACTOR_ONE, {FACTOR_BITS{1'b1}}};
        foreach (factors[i]) begin
            write_register(REG_CUT_FACTOR, factors[i]);
            send_vertex(make_vertex(24'h123456, 24'hFEDCBA), 1'b0);
            send_vertex(make_vertex(24'h800001, 24'h00FF00), 1'b1);
            wait_idle();
        end
        write_register(REG_CUT_FACTOR, FACTOR_RESET);
    endtask

    task automatic test_bypass_resume();
        send_vertex(make_vertex(24'h000100, 24'h000200), 1'b0);
        send_vertex(make_vertex(24'hFFF000, 24'h001000), 1'b0);
        wait_idle();
        write_register(REG_BYPASS, 17'h1);
        send_vertex(make_vertex(24'h7FFFFF, 24'h800000), 1'b0);
        send_vertex(make_vertex(24'h555555, 24'hAAAAAA), 1'b1);
        send_vertex(make_vertex(24'h800000, 24'h7FFFFF), 1'b0);
        wait_idle();
        write_register(REG_BYPASS, 17'h0);
        send_vertex(make_vertex(24'h003000, 24'hFFD000), 1'b0);
        send_vertex(make_vertex(24'hFFFF00, 24'h0000FF), 1'b1);
        wait_idle();
    endtask

    task automatic test_random_polygons();
        int sent;
        int phase;
        int poly_len;
        logic [FACTOR_BITS-1:0] data;
        sent = 0;
        phase = 0;
        while (sent < 210) begin
            wait_idle();
            calm = (phase >= 3) && (phase < 7);
            write_register(REG_CUT_FACTOR, random_factor());
            if ($urandom_range(3) == 0) begin
                data = FACTOR_BITS'($urandom);
                write_register(CFG_IDX_BITS'($urandom_range(REG_BYPASS + 1,
                                                            2**CFG_IDX_BITS - 1)), data);
            end
            data = FACTOR_BITS'($urandom);
            data[0] = ($urandom_range(7) == 0);
            write_register(REG_BYPASS, data);
            if (bypass_on) begin
                repeat ($urandom_range(3, 8)) begin
                    send_vertex(make_vertex(random_coord(), random_coord()),
                                1'($urandom_range(1)));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(2, 5)) begin
                    poly_len = ($urandom_range(9) < 2) ? $urandom_range(1, 2)
                                                        : $urandom_range(3, 8);
                    for (int k = 0; k < poly_len; k++) begin
                        send_vertex(make_vertex(random_coord(), random_coord()),
                                    (k == poly_len - 1) && ($urandom_range(9) != 0));
                        sent++;
                    end
                end
            end
            phase++;
        end
        calm = 1'b0;
        wait_idle();
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_polygon_shapes();
        test_factor_extremes();
        test_bypass_resume();
        test_random_polygons();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[polygon_corner_cutting.f]
rtl/core/pcc_pkg.sv
rtl/core/pcc_sequencer.sv
rtl/core/pcc_cut_pipe.sv
rtl/core/polygon_corner_cutting.sv
tb/testbench.sv
